### src/one_shot_timer_bank_unit_macros.svh
// Assertion macros for the timer bank unit.
`ifndef ONE_SHOT_TIMER_BANK_UNIT_MACROS_SVH
`define ONE_SHOT_TIMER_BANK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OSTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ostb_pkg.sv
package ostb_pkg;

    // Default bank size.
    localparam int NUM_TIMERS_DEF = 16;

    // Field widths.
    localparam int ACT_W   = 3;
    localparam int IDX_W   = 4;
    localparam int SECS_W  = 16;
    localparam int COUNT_W = 20;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd4;

    // Input transaction.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  timer_index;
        logic [SECS_W-1:0] seconds;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic [IDX_W-1:0] expired_index;
        logic             last_expiry;
    } t_out;

    // State of one timer.
    typedef struct packed {
        logic               active;
        logic               started;
        logic [COUNT_W-1:0] count;
    } t_timer;

    // Command broadcast to every cell.
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COUNT_W-1:0] ticks;
    } t_cmd;

endpackage

### src/ostb_cell.sv
module ostb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  ostb_pkg::t_timer i_shift_in,
    input  logic            i_sel,
    input  ostb_pkg::t_cmd  i_cmd,
    output ostb_pkg::t_timer o_state
);

    ostb_pkg::t_timer r_timer;
    ostb_pkg::t_timer n_timer;

    // Take the neighbor's record during a walk, or apply a command to this timer.
    always_comb begin
        n_timer = r_timer;
        if (i_shift) begin
            n_timer = i_shift_in;
        end else if (i_sel) begin
            case (i_cmd.action)
                ostb_pkg::ACT_START: begin
                    n_timer.count   = i_cmd.ticks;
                    n_timer.started = 1'b1;
                end
                ostb_pkg::ACT_STOP: begin
                    n_timer.started = 1'b0;
                end
                ostb_pkg::ACT_REGISTER: begin
                    n_timer.active  = 1'b1;
                    n_timer.started = 1'b0;
                    n_timer.count   = '0;
                end
                ostb_pkg::ACT_RELEASE: begin
                    n_timer.active = 1'b0;
                end
                default: begin
                    n_timer = r_timer;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
        end else begin
            r_timer <= n_timer;
        end
    end

    assign o_state = r_timer;

endmodule

### src/ostb_tick_proc.sv
module ostb_tick_proc (
    input  ostb_pkg::t_timer i_timer,
    output ostb_pkg::t_timer o_timer,
    output logic             o_expire
);

    // One tick on one timer: count down, or expire a started timer at zero.
    always_comb begin
        o_timer  = i_timer;
        o_expire = 1'b0;
        if (i_timer.active) begin
            if (i_timer.count != '0) begin
                o_timer.count = i_timer.count - ostb_pkg::COUNT_W'(1);
            end else if (i_timer.started) begin
                o_timer.started = 1'b0;
                o_expire        = 1'b1;
            end
        end
    end

endmodule

### src/one_shot_timer_bank_unit.sv
// Start, stop, register and release are written into the selected cell; one transaction
// per cycle while idle. A tick walks the ring of NUM_TIMERS cells, one timer per cycle
// unless a held expiry waits for a stalled output register, then ends in the flush
// state with the final result; the input is stalled until the tick is done.
// An expiry is held until the next one is found or the walk ends; the last result of a
// tick is loaded into the output register from the flush state.
// Synchronous active-low reset clears all flags and counts.
`include "one_shot_timer_bank_unit_macros.svh"

module one_shot_timer_bank_unit #(
    parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ostb_pkg::t_in  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output ostb_pkg::t_out o_out,
    input  logic           i_out_stall
);

    localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PW = (CW > ostb_pkg::IDX_W) ? CW : ostb_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] n_pos;
    logic r_pend_valid;
    logic n_pend_valid;
    logic [ostb_pkg::IDX_W-1:0] r_pend_idx;
    logic [ostb_pkg::IDX_W-1:0] n_pend_idx;
    logic r_out_valid;
    logic n_out_valid;
    ostb_pkg::t_out r_out;
    ostb_pkg::t_out n_out;

    logic in_acc;
    logic tick_acc;
    logic walking;
    logic in_range;
    logic cmd_valid;
    ostb_pkg::t_cmd cmd;
    logic shift;
    logic can_step;
    logic out_free;
    logic out_load;
    logic expire;
    logic [PW-1:0] pos_ext;
    logic [ostb_pkg::COUNT_W-1:0] secs_ext;
    ostb_pkg::t_timer ring [NUM_TIMERS];
    ostb_pkg::t_timer head_next;

    // Input handshake and command decode.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign tick_acc   = in_acc && (i_in.action == ostb_pkg::ACT_TICK);
    assign walking    = (r_state == ST_WALK);
    assign in_range   = (32'(i_in.timer_index) < NUM_TIMERS);
    assign cmd_valid  = in_acc && (i_in.action != ostb_pkg::ACT_TICK) && in_range;
    assign secs_ext   = ostb_pkg::COUNT_W'(i_in.seconds);
    assign cmd.action = i_in.action;
    assign cmd.ticks  = (secs_ext << 3) + (secs_ext << 1);

    // Tick processing at the head of the ring.
    ostb_tick_proc u_proc (
        .i_timer  (ring[0]),
        .o_timer  (head_next),
        .o_expire (expire)
    );

    // Ring of timer cells; the processed head record re-enters at the tail.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        ostb_pkg::t_timer shift_in;
        logic sel;
        if (g == NUM_TIMERS - 1) begin : g_tail
            assign shift_in = head_next;
        end else begin : g_body
            assign shift_in = ring[g+1];
        end
        assign sel = cmd_valid && (32'(i_in.timer_index) == g);
        ostb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (shift),
            .i_shift_in (shift_in),
            .i_sel      (sel),
            .i_cmd      (cmd),
            .o_state    (ring[g])
        );
    end

    // Walk control: the newest expiry is held back until we know whether it is the last.
    assign out_free = !r_out_valid || !i_out_stall;
    assign can_step = !(expire && r_pend_valid && !out_free);
    assign shift    = (r_state == ST_WALK) && can_step;
    assign pos_ext  = PW'(r_pos);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (tick_acc) begin
                    n_state = ST_WALK;
                    n_pos   = '0;
                end
            end
            ST_WALK: begin
                if (can_step) begin
                    if (expire) begin
                        if (r_pend_valid) begin
                            n_out.expired_index = r_pend_idx;
                            n_out.last_expiry   = 1'b0;
                            n_out_valid         = 1'b1;
                            out_load            = 1'b1;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = pos_ext[ostb_pkg::IDX_W-1:0];
                    end
                    if (r_pos == CW'(NUM_TIMERS - 1)) begin
                        n_state = ST_FLUSH;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out.expired_index = r_pend_idx;
                    n_out.last_expiry   = 1'b1;
                    n_out_valid         = 1'b1;
                    out_load            = 1'b1;
                    n_pend_valid        = 1'b0;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks on the walk sequencing.
    `OSTB_ASSERT_NOW(a_pend_only_busy, r_pend_valid, r_state != ST_IDLE, "pending while idle")
    `OSTB_ASSERT_NEXT(a_tick_starts_walk, tick_acc, walking, "tick did not walk")
    `OSTB_ASSERT_NEXT(a_walk_not_last, walking && out_load, !r_out.last_expiry, "early last")
    `OSTB_ASSERT_NEXT(a_blocked_holds, walking && !can_step, $stable(r_pos), "blocked walk moved")
    `OSTB_ASSERT_NOW(a_load_has_room, out_load, out_free, "output overwritten while stalled")

endmodule
